// ----- rtl/sfd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the serial frame deframer (sum-8 check).
// ----------------------------------------------------------------------------
package sfd_pkg;

   // Result kinds carried in tuser
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_GOOD    = 2'd1;
   localparam logic [1:0] KIND_BAD_SUM = 2'd2;
   localparam logic [1:0] KIND_BAD_VER = 2'd3;

   // Register indexes on the csr channel
   localparam logic [1:0] CSR_EXPECTED_VERSION = 2'd0;
   localparam logic [1:0] CSR_WANTED_TYPE      = 2'd1;
   localparam logic [1:0] CSR_FILTER_ENABLE    = 2'd2;

   // Register reset values
   localparam logic [7:0] EXPECTED_VERSION_RESET = 8'd1;
   localparam logic [7:0] WANTED_TYPE_RESET      = 8'h03;
   localparam logic       FILTER_ENABLE_RESET    = 1'b1;

   // Header "IMPROV"
   localparam int unsigned HDR_LEN = 6;
   localparam logic [7:0] HDR_I = 8'h49;
   localparam logic [7:0] HDR_M = 8'h4D;
   localparam logic [7:0] HDR_P = 8'h50;
   localparam logic [7:0] HDR_R = 8'h52;
   localparam logic [7:0] HDR_O = 8'h4F;
   localparam logic [7:0] HDR_V = 8'h56;

   // Wrapping sum of the header bytes, seed of the running checksum
   localparam logic [9:0] HDR_SUM_WIDE = {2'b00, HDR_I} + {2'b00, HDR_M} + {2'b00, HDR_P}
                                       + {2'b00, HDR_R} + {2'b00, HDR_O} + {2'b00, HDR_V};
   localparam logic [7:0] HDR_SUM = HDR_SUM_WIDE[7:0];

   // Expected header byte at a given match position
   function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
      logic [7:0] b;
      unique case (pos)
         3'd0:    b = HDR_I;
         3'd1:    b = HDR_M;
         3'd2:    b = HDR_P;
         3'd3:    b = HDR_R;
         3'd4:    b = HDR_O;
         3'd5:    b = HDR_V;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // One result item
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic [7:0] frame_type;
      logic [7:0] payload_index;
      logic [7:0] payload_length;
      logic       last;
   } result_type;

endpackage

// ----- rtl/serial_frame_deframer_sum8_core.sv -----
// ----------------------------------------------------------------------------
// serial_frame_deframer_sum8_core
// Hunts for IMPROV frames in a byte stream, streams payload bytes and closes
// each frame with a good / bad checksum / bad version status.
// ----------------------------------------------------------------------------
// A result is registered in the output register, or in its skid entry, before rsp.
// Throughput: one request per cycle while req_tready is high; per-byte frame state
//   update and the 8-bit checksum add are combinational ahead of a two-entry
//   output buffer; req_tready drops only while its skid entry is occupied.
// Reset (synchronous): hunting for the header, registers at their defaults,
//   output buffer empty.
module serial_frame_deframer_sum8_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] rx_byte
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,     // [7:0] data_byte, [15:8] frame_type,
                                      // [23:16] payload_index, [31:24] payload_length
   output logic [1:0]  rsp_tuser,     // [1:0] kind
   output logic        rsp_tlast,     // last
   // configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   // Frame phases
   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_VERSION = 3'd1;
   localparam logic [2:0] PH_TYPE    = 3'd2;
   localparam logic [2:0] PH_LENGTH  = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;
   localparam logic [2:0] PH_CHECK   = 3'd5;

   // Configuration registers
   logic [7:0] exp_ver_ff, exp_ver_in;
   logic [7:0] want_type_ff, want_type_in;
   logic       filt_en_ff, filt_en_in;

   // Frame state
   logic [2:0] phase_ff, phase_in;
   logic [2:0] hdr_pos_ff, hdr_pos_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] cur_type_ff, cur_type_in;
   logic [7:0] decl_len_ff, decl_len_in;
   logic [7:0] seen_ff, seen_in;
   logic       emit_ff, emit_in;
   logic       ver_bad_ff, ver_bad_in;

   // Output buffer
   logic                    out_valid_ff, out_valid_in;
   logic                    skid_valid_ff, skid_valid_in;
   sfd_pkg::result_type     out_ff, out_in;
   sfd_pkg::result_type     skid_ff, skid_in;

   logic                    accept;
   logic                    has_res;
   sfd_pkg::result_type     res;
   logic [7:0]              b;
   logic [7:0]              sum_add;
   logic [7:0]              seen_inc;
   logic [1:0]              status;
   logic [2:0]              hdr_next;
   logic                    pop;

   assign csr_ready  = 1'b1;
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign sum_add    = sum_ff + b;
   assign seen_inc   = seen_ff + 8'd1;

   // Register writes
   always_comb begin
      exp_ver_in   = exp_ver_ff;
      want_type_in = want_type_ff;
      filt_en_in   = filt_en_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sfd_pkg::CSR_EXPECTED_VERSION: exp_ver_in   = csr_data;
            sfd_pkg::CSR_WANTED_TYPE:      want_type_in = csr_data;
            sfd_pkg::CSR_FILTER_ENABLE:    filt_en_in   = csr_data[0];
            default: ;
         endcase
      end
   end

   // Frame status at the check byte; bad version wins over the checksum
   always_comb begin
      if (ver_bad_ff)
         status = sfd_pkg::KIND_BAD_VER;
      else if (sum_ff != b)
         status = sfd_pkg::KIND_BAD_SUM;
      else
         status = sfd_pkg::KIND_GOOD;
   end

   // Header match step: a mismatching 'I' restarts at position one
   always_comb begin
      if (b == sfd_pkg::hdr_byte(hdr_pos_ff))
         hdr_next = hdr_pos_ff + 3'd1;
      else if (b == sfd_pkg::HDR_I)
         hdr_next = 3'd1;
      else
         hdr_next = 3'd0;
   end

   // Per-byte frame state update
   always_comb begin
      phase_in    = phase_ff;
      hdr_pos_in  = hdr_pos_ff;
      sum_in      = sum_ff;
      cur_type_in = cur_type_ff;
      decl_len_in = decl_len_ff;
      seen_in     = seen_ff;
      emit_in     = emit_ff;
      ver_bad_in  = ver_bad_ff;
      has_res     = 1'b0;
      res.kind           = sfd_pkg::KIND_PAYLOAD;
      res.data_byte      = 8'd0;
      res.frame_type     = cur_type_ff;
      res.payload_index  = 8'd0;
      res.payload_length = decl_len_ff;
      res.last           = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PH_VERSION: begin
               sum_in     = sum_add;
               ver_bad_in = (b != exp_ver_ff);
               phase_in   = PH_TYPE;
            end
            PH_TYPE: begin
               sum_in      = sum_add;
               cur_type_in = b;
               emit_in     = !filt_en_ff || (b == want_type_ff);
               phase_in    = PH_LENGTH;
            end
            PH_LENGTH: begin
               sum_in      = sum_add;
               decl_len_in = b;
               seen_in     = 8'd0;
               phase_in    = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               sum_in  = sum_add;
               seen_in = seen_inc;
               if (seen_inc == decl_len_ff)
                  phase_in = PH_CHECK;
               has_res           = emit_ff;
               res.data_byte     = b;
               res.payload_index = seen_ff;
            end
            PH_CHECK: begin
               phase_in   = PH_HUNT;
               hdr_pos_in = 3'd0;
               has_res    = emit_ff;
               res.kind   = status;
               res.last   = 1'b1;
            end
            default: begin
               phase_in   = PH_HUNT;
               hdr_pos_in = hdr_next;
               if (hdr_next == 3'(sfd_pkg::HDR_LEN)) begin
                  sum_in     = sfd_pkg::HDR_SUM;
                  hdr_pos_in = 3'd0;
                  ver_bad_in = 1'b0;
                  phase_in   = PH_VERSION;
               end
            end
         endcase
      end
   end

   // Output register with skid entry
   assign pop = out_valid_ff && rsp_tready;
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (out_valid_ff && !pop) begin
         if (has_res) begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else begin
         out_valid_in = has_res;
         if (has_res)
            out_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ver_ff    <= sfd_pkg::EXPECTED_VERSION_RESET;
         want_type_ff  <= sfd_pkg::WANTED_TYPE_RESET;
         filt_en_ff    <= sfd_pkg::FILTER_ENABLE_RESET;
         phase_ff      <= PH_HUNT;
         hdr_pos_ff    <= 3'd0;
         sum_ff        <= 8'd0;
         cur_type_ff   <= 8'd0;
         decl_len_ff   <= 8'd0;
         seen_ff       <= 8'd0;
         emit_ff       <= 1'b0;
         ver_bad_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         exp_ver_ff    <= exp_ver_in;
         want_type_ff  <= want_type_in;
         filt_en_ff    <= filt_en_in;
         phase_ff      <= phase_in;
         hdr_pos_ff    <= hdr_pos_in;
         sum_ff        <= sum_in;
         cur_type_ff   <= cur_type_in;
         decl_len_ff   <= decl_len_in;
         seen_ff       <= seen_in;
         emit_ff       <= emit_in;
         ver_bad_ff    <= ver_bad_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.payload_length, out_ff.payload_index,
                        out_ff.frame_type, out_ff.data_byte};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last;

   // Checks
   skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   hdr_pos_range: assert property (@(posedge clock) disable iff (reset)
      hdr_pos_ff < 3'(sfd_pkg::HDR_LEN))
      else $error("header position reached full header length");

   payload_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (seen_ff < decl_len_ff))
      else $error("payload count beyond declared length");

   status_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |->
         (rsp_tuser != sfd_pkg::KIND_PAYLOAD && rsp_tdata[23:0] == 24'd0 ||
          rsp_tuser != sfd_pkg::KIND_PAYLOAD && rsp_tdata[7:0] == 8'd0))
      else $error("status result carries payload kind or data");

   full_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_tready) |=> skid_valid_ff && $stable(skid_ff))
      else $error("skid entry lost while stalled");

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for serial_frame_deframer_sum8_core. Streams of IMPROV
// frames, header fragments, noise and cut-short frames are sent one byte per
// request. Every payload byte and frame status that comes back is checked
// against a cycle-free model of the deframer kept in a scoreboard class.
// ----------------------------------------------------------------------------

class frame_result_scoreboard;

   typedef enum logic [2:0] {
      WAIT_HEADER, GET_VERSION, GET_TYPE, GET_LENGTH, GET_PAYLOAD, GET_CHECKSUM
   } parse_state_type;

   // register copies
   logic [7:0] cfg_version;
   logic [7:0] cfg_type;
   logic       cfg_filter;

   // parser state
   parse_state_type state;
   logic [2:0]   match_pos;
   logic [7:0]   sum;
   logic [7:0]   frame_type;
   logic [7:0]   frame_len;
   logic [7:0]   count;
   logic         pass_frame;
   logic         version_wrong;

   logic [7:0] header_seq [6];
   logic [7:0] header_sum;

   sfd_pkg::result_type expected_results [$];
   int errors;
   int kind_seen [4];

   function new();
      header_seq = '{sfd_pkg::HDR_I, sfd_pkg::HDR_M, sfd_pkg::HDR_P,
                     sfd_pkg::HDR_R, sfd_pkg::HDR_O, sfd_pkg::HDR_V};
      header_sum = 8'd0;
      foreach (header_seq[i]) header_sum = header_sum + header_seq[i];
      cfg_version   = sfd_pkg::EXPECTED_VERSION_RESET;
      cfg_type      = sfd_pkg::WANTED_TYPE_RESET;
      cfg_filter    = sfd_pkg::FILTER_ENABLE_RESET;
      state         = WAIT_HEADER;
      match_pos     = 3'd0;
      sum           = 8'd0;
      frame_type    = 8'd0;
      frame_len     = 8'd0;
      count         = 8'd0;
      pass_frame    = 1'b0;
      version_wrong = 1'b0;
      errors        = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
   endfunction

   function void write_register(logic [1:0] idx, logic [7:0] data);
      case (idx)
         sfd_pkg::CSR_EXPECTED_VERSION: cfg_version = data;
         sfd_pkg::CSR_WANTED_TYPE:      cfg_type    = data;
         sfd_pkg::CSR_FILTER_ENABLE:    cfg_filter  = data[0];
         default: ;  // unused index, dropped
      endcase
   endfunction

   // Advance the parser by one received byte, queue any result it yields
   function void predict_byte(logic [7:0] b);
      sfd_pkg::result_type r;
      logic [7:0] idx;
      r = '0;
      case (state)
         GET_VERSION: begin
            sum           = sum + b;
            version_wrong = (b != cfg_version);
            state         = GET_TYPE;
         end
         GET_TYPE: begin
            sum        = sum + b;
            frame_type = b;
            pass_frame = !cfg_filter || (b == cfg_type);
            state      = GET_LENGTH;
         end
         GET_LENGTH: begin
            sum       = sum + b;
            frame_len = b;
            count     = 8'd0;
            state     = (b == 8'd0) ? GET_CHECKSUM : GET_PAYLOAD;
         end
         GET_PAYLOAD: begin
            idx   = count;
            sum   = sum + b;
            count = count + 8'd1;
            if (count == frame_len) state = GET_CHECKSUM;
            if (pass_frame) begin
               r.kind           = sfd_pkg::KIND_PAYLOAD;
               r.data_byte      = b;
               r.frame_type     = frame_type;
               r.payload_index  = idx;
               r.payload_length = frame_len;
               r.last           = 1'b0;
               expected_results.push_back(r);
            end
         end
         GET_CHECKSUM: begin
            // a wrong version outranks a wrong checksum
            if (version_wrong)  r.kind = sfd_pkg::KIND_BAD_VER;
            else if (sum != b)  r.kind = sfd_pkg::KIND_BAD_SUM;
            else                r.kind = sfd_pkg::KIND_GOOD;
            state     = WAIT_HEADER;
            match_pos = 3'd0;
            if (pass_frame) begin
               r.frame_type     = frame_type;
               r.payload_length = frame_len;
               r.last           = 1'b1;
               expected_results.push_back(r);
            end
         end
         default: begin
            // header hunt; a stray 'I' restarts the match at its second letter
            if (match_pos < 3'd6 && b == header_seq[match_pos])
               match_pos = match_pos + 3'd1;
            else
               match_pos = (b == sfd_pkg::HDR_I) ? 3'd1 : 3'd0;
            if (match_pos == 3'd6) begin
               sum           = header_sum;
               match_pos     = 3'd0;
               version_wrong = 1'b0;
               state         = GET_VERSION;
            end
         end
      endcase
   endfunction

   function void check_result(sfd_pkg::result_type got);
      sfd_pkg::result_type want;
      kind_seen[got.kind]++;
      if (expected_results.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("ERROR: unexpected result kind=%0d data=%02h type=%02h idx=%0d len=%0d last=%0b",
                     got.kind, got.data_byte, got.frame_type, got.payload_index,
                     got.payload_length, got.last);
         return;
      end
      want = expected_results.pop_front();
      if (got.kind != want.kind || got.data_byte != want.data_byte ||
          got.frame_type != want.frame_type || got.payload_index != want.payload_index ||
          got.payload_length != want.payload_length || got.last != want.last) begin
         errors++;
         if (errors <= 10) begin
            $display("ERROR: expected kind=%0d data=%02h type=%02h idx=%0d len=%0d last=%0b",
                     want.kind, want.data_byte, want.frame_type, want.payload_index,
                     want.payload_length, want.last);
            $display("       actual   kind=%0d data=%02h type=%02h idx=%0d len=%0d last=%0b",
                     got.kind, got.data_byte, got.frame_type, got.payload_index,
                     got.payload_length, got.last);
         end
      end
   endfunction

   function int outstanding();
      return expected_results.size();
   endfunction

endclass

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CSR_UNUSED = 2'd3;   // no register behind this index

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [7:0]  csr_data;

   frame_result_scoreboard sb;

   int         send_idle_pct;
   int         recv_idle_pct;
   int         bytes_sent;
   int         hold_left;
   bit         hold_order;
   bit         hold_taken;
   logic [7:0] cur_version;
   logic [7:0] cur_wanted;

   serial_frame_deframer_sum8_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random back-pressure, plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      hold_left  = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_order && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin
      sfd_pkg::result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind           = rsp_tuser;
         got.data_byte      = rsp_tdata[7:0];
         got.frame_type     = rsp_tdata[15:8];
         got.payload_index  = rsp_tdata[23:16];
         got.payload_length = rsp_tdata[31:24];
         got.last           = rsp_tlast;
         sb.check_result(got);
      end
   end

   // Send one byte as a request, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      sb.predict_byte(b);
      bytes_sent++;
   endtask

   // Header, version, type, length, n payload bytes, then optionally the checksum
   task automatic send_frame(input logic [7:0] ver, input logic [7:0] typ,
                             input logic [7:0] len, input int n_payload,
                             input bit with_check, input bit corrupt);
      logic [7:0] s;
      logic [7:0] b;
      s = 8'd0;
      foreach (sb.header_seq[i]) begin
         send_byte(sb.header_seq[i]);
         s = s + sb.header_seq[i];
      end
      send_byte(ver);
      send_byte(typ);
      send_byte(len);
      s = s + ver + typ + len;
      for (int i = 0; i < n_payload; i++) begin
         b = 8'($urandom_range(0, 255));
         send_byte(b);
         s = s + b;
      end
      if (with_check)
         send_byte(corrupt ? s + 8'($urandom_range(1, 255)) : s);
   endtask

   task automatic random_traffic(input int n_bytes);
      int         target;
      int         pick;
      int         k;
      logic [7:0] len;
      target = bytes_sent + n_bytes;
      while (bytes_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            // well-formed frame, random content, mostly short
            k = $urandom_range(0, 99);
            if (k < 2)       len = 8'd255;
            else if (k < 5)  len = 8'($urandom_range(13, 254));
            else if (k < 15) len = 8'd0;
            else             len = 8'($urandom_range(1, 12));
            send_frame(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : cur_version,
                       ($urandom_range(0, 9) < 7) ? cur_wanted : 8'($urandom_range(0, 255)),
                       len, int'(len), 1'b1, ($urandom_range(0, 99) < 15));
         end else if (pick < 82) begin
            // header fragment broken off by a random byte
            k = $urandom_range(1, 5);
            for (int i = 0; i < k; i++) send_byte(sb.header_seq[i]);
            send_byte(8'($urandom_range(0, 255)));
         end else if (pick < 92) begin
            // line noise
            k = $urandom_range(1, 8);
            repeat (k) send_byte(8'($urandom_range(0, 255)));
         end else begin
            // frame cut short, later bytes are swallowed as its remainder
            len = 8'($urandom_range(1, 12));
            send_frame(cur_version, cur_wanted, len,
                       int'($urandom_range(0, int'(len) - 1)), 1'b0, 1'b0);
         end
      end
   endtask

   // Stop offering and let the block run dry before touching registers
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [7:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(idx, data);
   endtask

   task automatic apply_settings(input logic [7:0] ver, input logic [7:0] typ,
                                 input logic [7:0] filt);
      csr_write(sfd_pkg::CSR_EXPECTED_VERSION, ver);
      csr_write(sfd_pkg::CSR_WANTED_TYPE, typ);
      csr_write(sfd_pkg::CSR_FILTER_ENABLE, filt);
      csr_write(CSR_UNUSED, 8'($urandom_range(0, 255)));
      @(negedge clock);
      csr_valid  <= 1'b0;
      cur_version = ver;
      cur_wanted  = typ;
   endtask

   // Main sequence
   initial begin
      int guard;
      int failures;
      sb            = new();
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'd0;
      csr_valid     = 1'b0;
      csr_index     = sfd_pkg::CSR_EXPECTED_VERSION;
      csr_data      = 8'd0;
      hold_order    = 1'b0;
      bytes_sent    = 0;
      send_idle_pct = 29;
      recv_idle_pct = 69;
      cur_version   = sfd_pkg::EXPECTED_VERSION_RESET;
      cur_wanted    = sfd_pkg::WANTED_TYPE_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: header restart on a stray 'I', one 0xFF payload byte,
      // then a zero-length frame with version 0x00 (bad version)
      send_byte(sfd_pkg::HDR_I);
      send_byte(sfd_pkg::HDR_M);
      send_byte(sfd_pkg::HDR_P);
      send_frame(sfd_pkg::EXPECTED_VERSION_RESET, sfd_pkg::WANTED_TYPE_RESET, 8'd1, 0,
                 1'b0, 1'b0);
      send_byte(8'hFF);
      send_byte(sb.header_sum + sfd_pkg::EXPECTED_VERSION_RESET + sfd_pkg::WANTED_TYPE_RESET
                + 8'd1 + 8'hFF);
      send_frame(8'h00, sfd_pkg::WANTED_TYPE_RESET, 8'd0, 0, 1'b1, 1'b0);
      drain();

      // sender light idling, receiver heavy
      apply_settings(8'h00, 8'hFF, 8'h01);
      random_traffic(580);
      drain();

      // swapped idling; filter off via a write whose bit 0 is clear
      send_idle_pct = 69;
      recv_idle_pct = 29;
      apply_settings(8'hFF, 8'h00, 8'hFE);
      random_traffic(580);
      drain();

      // full rate, with one long receiver hold-off to back the block up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     {7'($urandom_range(0, 127)), 1'b1});
      random_traffic(150);
      hold_order = 1'b1;
      random_traffic(430);

      @(negedge clock);
      req_tvalid <= 1'b0;
      guard = 0;
      while (sb.outstanding() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes: reset register values, then three written settings",
               bytes_sent);
      $display("under three idling patterns. Results seen: %0d payload, %0d good, %0d bad checksum, %0d bad version.",
               sb.kind_seen[sfd_pkg::KIND_PAYLOAD], sb.kind_seen[sfd_pkg::KIND_GOOD],
               sb.kind_seen[sfd_pkg::KIND_BAD_SUM], sb.kind_seen[sfd_pkg::KIND_BAD_VER]);
      failures = sb.errors + sb.outstanding();
      if (failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d results never arrived", sb.errors, sb.outstanding());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5000000;
      $display("Timed out with %0d results outstanding", sb.outstanding());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
